### hw/rtl/psd_pkg.sv
`default_nettype none
package psd_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int PARAM_FRAC  = 24;
	localparam int DIST_WIDTH  = 25;

	localparam int D_W    = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * D_W;
	localparam int LEN_W  = 2 * D_W;
	localparam int DOT_W  = LEN_W + 1;
	localparam int T_W    = PARAM_FRAC + 1;
	localparam int SP_W   = T_W + D_W;
	localparam int RX_W   = D_W + 1;
	localparam int UX_W   = D_W;
	localparam int SQ_W   = 2 * UX_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int N_W    = 2 * ROOT_W;
	localparam int R_W    = ROOT_W + 2;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = $clog2(MQ_DEPTH);

	localparam logic [T_W-1:0]        T_ONE    = T_W'(1) << PARAM_FRAC;
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [D_W-1:0]         delta_t;

	typedef enum logic [1:0] {
		RG_START    = 2'd0,
		RG_INTERIOR = 2'd1,
		RG_END      = 2'd2,
		RG_DEGEN    = 2'd3
	} region_t;

	typedef struct packed {
		region_t          region;
		logic             tone;
		logic [LEN_W-1:0] num;
		logic [LEN_W-1:0] den;
		coord_t           px;
		coord_t           py;
		coord_t           sx;
		coord_t           sy;
		coord_t           ex;
		coord_t           ey;
		delta_t           dx;
		delta_t           dy;
	} mid_t;

	typedef struct packed {
		logic [DIST_WIDTH-1:0] distance;
		region_t               region;
	} res_t;

endpackage
`default_nettype wire

### hw/rtl/psd_front.sv
`default_nettype none
module psd_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire  psd_pkg::coord_t        query_x,
	input  wire  psd_pkg::coord_t        query_y,
	input  wire  psd_pkg::coord_t        seg_start_x,
	input  wire  psd_pkg::coord_t        seg_start_y,
	input  wire  psd_pkg::coord_t        seg_end_x,
	input  wire  psd_pkg::coord_t        seg_end_y,
	input  wire                          mq_full,
	output logic                         mq_push,
	output psd_pkg::mid_t                mq_data
);
	import psd_pkg::*;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	coord_t px_s1, py_s1, sx_s1, sy_s1, ex_s1, ey_s1;
	delta_t dx_s1, dy_s1, wx_s1, wy_s1;
	logic   degen_s1;

	coord_t px_s2, py_s2, sx_s2, sy_s2, ex_s2, ey_s2;
	delta_t dx_s2, dy_s2;
	logic   degen_s2;
	logic signed [PROD_W-1:0] dxdx_s2, dydy_s2, wxdx_s2, wydy_s2;

	coord_t px_s3, py_s3, sx_s3, sy_s3, ex_s3, ey_s3;
	delta_t dx_s3, dy_s3;
	logic   degen_s3;
	logic [LEN_W-1:0]        len2_s3;
	logic signed [DOT_W-1:0] dot_s3;

	mid_t mid_s4;

	delta_t dx_in, dy_in, wx_in, wy_in;
	region_t rg_cls;

	assign en      = !vld_s4 || !mq_full;
	assign full    = !en;
	assign mq_push = en && vld_s4;
	assign mq_data = mid_s4;

	assign dx_in = D_W'(seg_end_x) - D_W'(seg_start_x);
	assign dy_in = D_W'(seg_end_y) - D_W'(seg_start_y);
	assign wx_in = D_W'(query_x) - D_W'(seg_start_x);
	assign wy_in = D_W'(query_y) - D_W'(seg_start_y);

	always_comb begin
		if (degen_s3)
			rg_cls = RG_DEGEN;
		else if (dot_s3 < 0)
			rg_cls = RG_START;
		else if (dot_s3 > $signed({1'b0, len2_s3}))
			rg_cls = RG_END;
		else
			rg_cls = RG_INTERIOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= query_x;
			py_s1    <= query_y;
			sx_s1    <= seg_start_x;
			sy_s1    <= seg_start_y;
			ex_s1    <= seg_end_x;
			ey_s1    <= seg_end_y;
			dx_s1    <= dx_in;
			dy_s1    <= dy_in;
			wx_s1    <= wx_in;
			wy_s1    <= wy_in;
			degen_s1 <= (dx_in == '0) && (dy_in == '0);

			px_s2    <= px_s1;
			py_s2    <= py_s1;
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			ex_s2    <= ex_s1;
			ey_s2    <= ey_s1;
			dx_s2    <= dx_s1;
			dy_s2    <= dy_s1;
			degen_s2 <= degen_s1;
			dxdx_s2  <= PROD_W'(dx_s1) * PROD_W'(dx_s1);
			dydy_s2  <= PROD_W'(dy_s1) * PROD_W'(dy_s1);
			wxdx_s2  <= PROD_W'(wx_s1) * PROD_W'(dx_s1);
			wydy_s2  <= PROD_W'(wy_s1) * PROD_W'(dy_s1);

			px_s3    <= px_s2;
			py_s3    <= py_s2;
			sx_s3    <= sx_s2;
			sy_s3    <= sy_s2;
			ex_s3    <= ex_s2;
			ey_s3    <= ey_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			degen_s3 <= degen_s2;
			len2_s3  <= LEN_W'(dxdx_s2) + LEN_W'(dydy_s2);
			dot_s3   <= DOT_W'(wxdx_s2) + DOT_W'(wydy_s2);

			mid_s4.region <= rg_cls;
			mid_s4.tone   <= (dot_s3 == $signed({1'b0, len2_s3}));
			mid_s4.num    <= dot_s3[LEN_W-1:0];
			mid_s4.den    <= len2_s3;
			mid_s4.px     <= px_s3;
			mid_s4.py     <= py_s3;
			mid_s4.sx     <= sx_s3;
			mid_s4.sy     <= sy_s3;
			mid_s4.ex     <= ex_s3;
			mid_s4.ey     <= ey_s3;
			mid_s4.dx     <= dx_s3;
			mid_s4.dy     <= dy_s3;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/psd_mid_q.sv
`default_nettype none
module psd_mid_q (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr,
	input  wire  psd_pkg::mid_t wdata,
	output logic                full,
	input  wire                 rd,
	output psd_pkg::mid_t       rdata,
	output logic                empty
);
	import psd_pkg::*;

	mid_t             mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wp_q, rp_q;
	logic [MQ_AW:0]   cnt_q;

	assign full  = (cnt_q == (MQ_AW+1)'(MQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/psd_back.sv
`default_nettype none
module psd_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                mq_empty,
	output logic                               mq_rd,
	input  wire  psd_pkg::mid_t                mq_data,
	input  wire                                pop,
	output logic                               empty,
	output logic [psd_pkg::DIST_WIDTH-1:0]     distance,
	output logic [1:0]                         region
);
	import psd_pkg::*;

	localparam int DIV_N = PARAM_FRAC;
	localparam int I_MUL = DIV_N + 1;
	localparam int I_SQ0 = DIV_N + 5;
	localparam int NB    = I_SQ0 + ROOT_W + 1;

	logic          en;
	logic [NB-1:0] vld_q;

	// fraction divider, one quotient bit per stage
	mid_t                  div_ctx_s [DIV_N+1];
	logic [LEN_W-1:0]      div_num_s [DIV_N+1];
	logic [PARAM_FRAC-1:0] div_q_s   [DIV_N+1];
	logic [LEN_W:0]        div_two   [DIV_N];
	logic [LEN_W:0]        div_dif   [DIV_N];

	mid_t            mul_ctx_s;
	logic [SP_W-1:0] prod_x_s, prod_y_s;
	logic [T_W-1:0]  t_val;
	logic [D_W-1:0]  mag_x, mag_y;

	coord_t  px_cx_s, py_cx_s;
	delta_t  cx_s, cy_s;
	region_t rg_cx_s;
	delta_t  p_x, p_y, sx_e, sy_e;

	logic [UX_W-1:0]       ux_s, uy_s;
	region_t               rg_ux_s;
	logic signed [RX_W-1:0] rx, ry;

	logic [SQ_W-1:0] sqx_s, sqy_s;
	region_t         rg_sqr_s;

	// digit-by-digit square root, one root bit per stage
	logic [N_W-1:0]    sq_n_s  [ROOT_W+1];
	logic [R_W-1:0]    sq_r_s  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_q_s  [ROOT_W+1];
	region_t           sq_rg_s [ROOT_W+1];
	logic [R_W-1:0]    sq_cur  [ROOT_W];
	logic [R_W-1:0]    sq_try  [ROOT_W];

	res_t           oq_mem_q [2];
	logic           oq_wp_q, oq_rp_q;
	logic [1:0]     oq_cnt_q;
	logic           oq_full, oq_wr, oq_rd;
	logic [ROOT_W-1:0] root;
	res_t           res_new;

	assign oq_full = (oq_cnt_q == 2'd2);
	assign en      = !vld_q[NB-1] || !oq_full;
	assign mq_rd   = en && !mq_empty;
	assign oq_wr   = en && vld_q[NB-1];
	assign empty   = (oq_cnt_q == 2'd0);
	assign oq_rd   = pop && !empty;
	assign distance = oq_mem_q[oq_rp_q].distance;
	assign region   = oq_mem_q[oq_rp_q].region;

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			div_two[k] = {div_num_s[k], 1'b0};
			div_dif[k] = div_two[k] - {1'b0, div_ctx_s[k].den};
		end
	end

	assign t_val = div_ctx_s[DIV_N].tone ? T_ONE : {1'b0, div_q_s[DIV_N]};
	assign mag_x = div_ctx_s[DIV_N].dx[D_W-1] ? D_W'(-div_ctx_s[DIV_N].dx)
	                                          : D_W'(div_ctx_s[DIV_N].dx);
	assign mag_y = div_ctx_s[DIV_N].dy[D_W-1] ? D_W'(-div_ctx_s[DIV_N].dy)
	                                          : D_W'(div_ctx_s[DIV_N].dy);

	assign p_x  = prod_x_s[PARAM_FRAC +: D_W];
	assign p_y  = prod_y_s[PARAM_FRAC +: D_W];
	assign sx_e = D_W'(mul_ctx_s.sx);
	assign sy_e = D_W'(mul_ctx_s.sy);

	assign rx = RX_W'(px_cx_s) - RX_W'(cx_s);
	assign ry = RX_W'(py_cx_s) - RX_W'(cy_s);

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			sq_cur[k] = {sq_r_s[k][R_W-3:0], sq_n_s[k][N_W-1 -: 2]};
			sq_try[k] = {sq_q_s[k], 2'b01};
		end
	end

	assign root = sq_q_s[ROOT_W];
	always_comb begin
		res_new.region = sq_rg_s[ROOT_W];
		if (root > ROOT_W'(DIST_MAX))
			res_new.distance = DIST_MAX;
		else
			res_new.distance = root[DIST_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NB-2:0], !mq_empty};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_ctx_s[0] <= mq_data;
			div_num_s[0] <= mq_data.num;
			div_q_s[0]   <= '0;
			for (int k = 0; k < DIV_N; k++) begin
				div_ctx_s[k+1] <= div_ctx_s[k];
				if (!div_dif[k][LEN_W]) begin
					div_num_s[k+1] <= div_dif[k][LEN_W-1:0];
					div_q_s[k+1]   <= {div_q_s[k][PARAM_FRAC-2:0], 1'b1};
				end else begin
					div_num_s[k+1] <= div_two[k][LEN_W-1:0];
					div_q_s[k+1]   <= {div_q_s[k][PARAM_FRAC-2:0], 1'b0};
				end
			end

			mul_ctx_s <= div_ctx_s[DIV_N];
			prod_x_s  <= SP_W'(t_val) * SP_W'(mag_x);
			prod_y_s  <= SP_W'(t_val) * SP_W'(mag_y);

			px_cx_s <= mul_ctx_s.px;
			py_cx_s <= mul_ctx_s.py;
			rg_cx_s <= mul_ctx_s.region;
			case (mul_ctx_s.region)
				RG_INTERIOR: begin
					cx_s <= mul_ctx_s.dx[D_W-1] ? sx_e - p_x : sx_e + p_x;
					cy_s <= mul_ctx_s.dy[D_W-1] ? sy_e - p_y : sy_e + p_y;
				end
				RG_END: begin
					cx_s <= D_W'(mul_ctx_s.ex);
					cy_s <= D_W'(mul_ctx_s.ey);
				end
				default: begin
					cx_s <= sx_e;
					cy_s <= sy_e;
				end
			endcase

			ux_s    <= rx[RX_W-1] ? UX_W'(-rx) : UX_W'(rx);
			uy_s    <= ry[RX_W-1] ? UX_W'(-ry) : UX_W'(ry);
			rg_ux_s <= rg_cx_s;

			sqx_s    <= SQ_W'(ux_s) * SQ_W'(ux_s);
			sqy_s    <= SQ_W'(uy_s) * SQ_W'(uy_s);
			rg_sqr_s <= rg_ux_s;

			sq_n_s[0]  <= N_W'(SUM_W'(sqx_s) + SUM_W'(sqy_s));
			sq_r_s[0]  <= '0;
			sq_q_s[0]  <= '0;
			sq_rg_s[0] <= rg_sqr_s;
			for (int k = 0; k < ROOT_W; k++) begin
				sq_n_s[k+1]  <= {sq_n_s[k][N_W-3:0], 2'b00};
				sq_rg_s[k+1] <= sq_rg_s[k];
				if (sq_cur[k] >= sq_try[k]) begin
					sq_r_s[k+1] <= sq_cur[k] - sq_try[k];
					sq_q_s[k+1] <= {sq_q_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					sq_r_s[k+1] <= sq_cur[k];
					sq_q_s[k+1] <= {sq_q_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// two-entry result queue decouples pop from the pipeline
	always_ff @(posedge clk) begin
		if (oq_wr)
			oq_mem_q[oq_wp_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_wr)
				oq_wp_q <= !oq_wp_q;
			if (oq_rd)
				oq_rp_q <= !oq_rp_q;
			if (oq_wr && !oq_rd)
				oq_cnt_q <= oq_cnt_q + 2'd1;
			else if (oq_rd && !oq_wr)
				oq_cnt_q <= oq_cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/point_segment_distance_top.sv
// Throughput: one item per cycle while results are popped, set by the fully
// pipelined divider (one quotient bit a stage) and square root (one root bit a stage).
// Front (4 stages) and back (56 stages) stall independently across a 4-entry queue.
// Reset: arst_n clears all valid bits and queue pointers; the block is empty after reset.
`default_nettype none
module point_segment_distance_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            push,
	output logic                           full,
	input  wire  psd_pkg::coord_t          query_x,
	input  wire  psd_pkg::coord_t          query_y,
	input  wire  psd_pkg::coord_t          seg_start_x,
	input  wire  psd_pkg::coord_t          seg_start_y,
	input  wire  psd_pkg::coord_t          seg_end_x,
	input  wire  psd_pkg::coord_t          seg_end_y,
	output logic                           empty,
	input  wire                            pop,
	output logic [psd_pkg::DIST_WIDTH-1:0] distance,
	output logic [1:0]                     region
);
	import psd_pkg::*;

	logic mq_push, mq_full, mq_rd, mq_empty;
	mid_t mq_wdata, mq_rdata;

	psd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.query_x     (query_x),
		.query_y     (query_y),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.mq_full     (mq_full),
		.mq_push     (mq_push),
		.mq_data     (mq_wdata)
	);

	psd_mid_q u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.rd     (mq_rd),
		.rdata  (mq_rdata),
		.empty  (mq_empty)
	);

	psd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_empty (mq_empty),
		.mq_rd    (mq_rd),
		.mq_data  (mq_rdata),
		.pop      (pop),
		.empty    (empty),
		.distance (distance),
		.region   (region)
	);

endmodule
`default_nettype wire

### hw/rtl/psd_checker.sv
`default_nettype none
module psd_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            push,
	input wire                            full,
	input wire                            empty,
	input wire                            pop,
	input wire [psd_pkg::DIST_WIDTH-1:0]  distance,
	input wire [1:0]                      region
);
	logic [7:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 8'(push && !full) - 8'(pop && !empty);
	end

	// a result can only show for an item that was transferred in
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> inflight_q != '0)
		else $error("result shown with no item outstanding");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(distance) && $stable(region))
		else $error("waiting result changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == '0 |-> empty)
		else $error("result queue not empty with nothing outstanding");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({distance, region}))
		else $error("waiting result has unknown bits");

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (.*);
`default_nettype wire
